### sv/pdve_pkg.sv
// pdve_pkg: constants shared by the position delta varint encoder
// no dependencies; imported by pdve_delta, pdve_varint and the top level
`timescale 1ns / 1ps
`default_nettype none

package pdve_pkg;

	// input field widths
	localparam int OFFSET_BITS = 31;
	localparam int SOURCE_BITS = 32;
	localparam int S_TDATA_BITS = 64;

	// widest supported integer width
	localparam int MAX_INT_BITS = 64;

	// digit width of the serial subtractor
	localparam int DIGIT_BITS = 8;

	// varint byte layout
	localparam int BYTE_BITS = 8;
	localparam int PAYLOAD_BITS = 7;
	localparam int MORE_BIT = 7;

endpackage

`default_nettype wire

### sv/pdve_delta.sv
// pdve_delta: digit-serial subtraction of the previous entry, flag fold and zig-zag
// depends on pdve_pkg; holds the previous offset and source position
`timescale 1ns / 1ps
`default_nettype none

module pdve_delta #(
	parameter int INT_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [INT_BITS-1:0] off_in,
	input  wire logic [INT_BITS-1:0] src_in,
	input  wire logic                stmt_in,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output logic [INT_BITS-1:0]      off_code,
	output logic [INT_BITS-1:0]      src_code,
	output logic                     res_err
);
	import pdve_pkg::*;

	localparam int NDIG = (INT_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PW = NDIG * DIGIT_BITS;
	localparam int CW = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic [PW-1:0] a_off_q, b_off_q, a_src_q, b_src_q;
	logic          br_off_q, br_src_q;
	logic          busy_q, done_q, stmt_q, err_q;
	logic [CW-1:0] cnt_q;

	logic [DIGIT_BITS:0]   sub_off, sub_src;
	logic [INT_BITS-1:0]   d_off, folded, d_src;
	logic                  last_digit;

	// one digit of each difference per cycle, borrow carried between digits
	assign sub_off = {1'b0, a_off_q[DIGIT_BITS-1:0]} - {1'b0, b_off_q[DIGIT_BITS-1:0]}
		- (DIGIT_BITS + 1)'(br_off_q);
	assign sub_src = {1'b0, a_src_q[DIGIT_BITS-1:0]} - {1'b0, b_src_q[DIGIT_BITS-1:0]}
		- (DIGIT_BITS + 1)'(br_src_q);
	assign last_digit = (cnt_q == CW'(NDIG - 1));

	assign in_ready = !busy_q && !done_q;
	assign res_valid = done_q;
	assign res_err = err_q;

	// flag fold and zig-zag, bitwise over the finished differences
	assign d_off = a_off_q[INT_BITS-1:0];
	assign d_src = a_src_q[INT_BITS-1:0];
	assign folded = stmt_q ? d_off : ~d_off;
	assign off_code = {folded[INT_BITS-2:0], 1'b0} ^ {INT_BITS{folded[INT_BITS-1]}};
	assign src_code = {d_src[INT_BITS-2:0], 1'b0} ^ {INT_BITS{d_src[INT_BITS-1]}};

	// control state and previous-entry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			b_off_q <= '0;
			b_src_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				// current digit moves into the previous-entry register as it is used
				b_off_q <= {a_off_q[DIGIT_BITS-1:0], b_off_q[PW-1:DIGIT_BITS]};
				b_src_q <= {a_src_q[DIGIT_BITS-1:0], b_src_q[PW-1:DIGIT_BITS]};
				cnt_q <= cnt_q + CW'(1);
				if (last_digit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && res_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	// operand shift registers; difference digits fill in from the top
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_off_q <= PW'(off_in);
			a_src_q <= PW'(src_in);
			br_off_q <= 1'b0;
			br_src_q <= 1'b0;
			stmt_q <= stmt_in;
		end else if (busy_q) begin
			a_off_q <= {sub_off[DIGIT_BITS-1:0], a_off_q[PW-1:DIGIT_BITS]};
			a_src_q <= {sub_src[DIGIT_BITS-1:0], a_src_q[PW-1:DIGIT_BITS]};
			br_off_q <= sub_off[DIGIT_BITS];
			br_src_q <= sub_src[DIGIT_BITS];
			// final borrow of the offset lane means it went backwards
			if (last_digit) begin
				err_q <= sub_off[DIGIT_BITS];
			end
		end
	end

endmodule

`default_nettype wire

### sv/pdve_varint.sv
// pdve_varint: 7-bit varint byte emitter with a registered output stage
// depends on pdve_pkg; fed with the two zig-zag codes of one entry
`timescale 1ns / 1ps
`default_nettype none

module pdve_varint #(
	parameter int INT_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        code_valid,
	output logic                             code_ready,
	input  wire logic [INT_BITS-1:0]         off_code,
	input  wire logic [INT_BITS-1:0]         src_code,
	input  wire logic                        err_in,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [pdve_pkg::BYTE_BITS-1:0]   out_byte,
	output logic                             out_last,
	output logic                             out_err
);
	import pdve_pkg::*;

	logic [INT_BITS-1:0]  sh_q, src_q;
	logic                 busy_q, sel_q, err_q;
	logic                 ov_q, olast_q, oerr_q;
	logic [BYTE_BITS-1:0] obyte_q;
	logic                 more, step;

	// more bytes follow while any bit above the payload is set
	assign more = |sh_q[INT_BITS-1:PAYLOAD_BITS];
	assign step = busy_q && (!ov_q || out_ready);

	assign code_ready = !busy_q;
	assign out_valid = ov_q;
	assign out_byte = obyte_q;
	assign out_last = olast_q;
	assign out_err = oerr_q;

	// control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (code_valid && code_ready) begin
				busy_q <= 1'b1;
				sel_q <= 1'b0;
			end else if (step) begin
				if (!more) begin
					sel_q <= 1'b1;
					if (sel_q) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (step) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// code shift register and output byte
	always_ff @(posedge clk) begin
		if (code_valid && code_ready) begin
			sh_q <= off_code;
			src_q <= src_code;
			err_q <= err_in;
		end else if (step) begin
			if (more) begin
				sh_q <= sh_q >> PAYLOAD_BITS;
			end else begin
				sh_q <= src_q;
			end
		end
		if (step) begin
			obyte_q <= {more, sh_q[PAYLOAD_BITS-1:0]};
			olast_q <= !more && sel_q;
			oerr_q <= err_q;
		end
	end

endmodule

`default_nettype wire

### sv/position_delta_varint_encoder_unit.sv
// channel | dir | tdata                          | tuser          | tlast
// s_*     | in  | code_offset, source_pos        | statement_flag | -
// m_*     | out | code_byte                      | order_error    | last_of_entry
//
// an entry is subtracted over ceil(INT_BITS/8) digits (4 at 32 bits) and handed to the emitter,
// then emitted one byte per cycle while m_tready is high, 2 to 2*ceil(INT_BITS/7) bytes (10 at 32 bits)
// the next entry is subtracted while the previous one is still being emitted
// arst_n clears the previous offset and source position to zero
// m_tready low holds the output byte; the emitter and then s_tready stall behind it
//
// position_delta_varint_encoder_unit: top level of the position delta varint encoder
// depends on pdve_pkg, pdve_delta and pdve_varint
`timescale 1ns / 1ps
`default_nettype none

module position_delta_varint_encoder_unit #(
	parameter int INT_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [30:0] code_offset, [62:31] source_pos, [63] zero pad
	input  wire logic [pdve_pkg::S_TDATA_BITS-1:0] s_tdata,
	// [0] statement_flag
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [7:0] code_byte
	output logic [pdve_pkg::BYTE_BITS-1:0]        m_tdata,
	// [0] order_error
	output logic                                  m_tuser,
	output logic                                  m_tlast
);
	import pdve_pkg::*;

	logic [MAX_INT_BITS-1:0] off_ext, src_ext;
	logic [INT_BITS-1:0]     off_w, src_w, off_code, src_code;
	logic                    delta_valid, code_ready, delta_err;

	// offset zero-extended, source sign-extended, both cut to the integer width
	assign off_ext = {{(MAX_INT_BITS - OFFSET_BITS){1'b0}}, s_tdata[OFFSET_BITS-1:0]};
	assign src_ext = {{(MAX_INT_BITS - SOURCE_BITS){s_tdata[OFFSET_BITS+SOURCE_BITS-1]}},
		s_tdata[OFFSET_BITS+SOURCE_BITS-1:OFFSET_BITS]};
	assign off_w = off_ext[INT_BITS-1:0];
	assign src_w = src_ext[INT_BITS-1:0];

	// serial differences and zig-zag codes
	pdve_delta #(
		.INT_BITS(INT_BITS)
	) u_delta (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.off_in   (off_w),
		.src_in   (src_w),
		.stmt_in  (s_tuser),
		.res_valid(delta_valid),
		.res_ready(code_ready),
		.off_code (off_code),
		.src_code (src_code),
		.res_err  (delta_err)
	);

	// varint byte emission
	pdve_varint #(
		.INT_BITS(INT_BITS)
	) u_varint (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_valid(delta_valid),
		.code_ready(code_ready),
		.off_code  (off_code),
		.src_code  (src_code),
		.err_in    (delta_err),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_err   (m_tuser)
	);

`ifndef SYNTH
	// the final byte of an entry never carries the continuation bit
	a_last_no_more: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[MORE_BIT])
		else $error("last byte of entry has continuation bit set");

	// input is only taken while no finished difference is waiting
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !delta_valid)
		else $error("input ready while a difference result is pending");

	// the subtractor is busy in the cycle after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !delta_valid)
		else $error("subtractor not busy after accepting an item");
`endif

endmodule

`default_nettype wire

### test/tb_position_delta_varint_encoder_unit.sv
// tb_position_delta_varint_encoder_unit: self-checking bench for the position delta varint encoder
// predicts the zig-zag varint bytes of every accepted entry and checks each output item in order
// depends on pdve_pkg and position_delta_varint_encoder_unit
`timescale 1ns / 1ps
`default_nettype none

module tb_position_delta_varint_encoder_unit;

	import pdve_pkg::*;

	localparam int PAD_BITS = S_TDATA_BITS - OFFSET_BITS - SOURCE_BITS;
	// idle wait after the output drains, longer than the subtractor digits plus the longest byte run
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLDOFF_CYCLES = 200;

	typedef struct packed {
		logic [BYTE_BITS-1:0] code_byte;
		logic                 last_of_entry;
		logic                 order_error;
	} enc_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [BYTE_BITS-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	// previous entry as the block should hold it
	logic [31:0] prev_offset;
	logic [31:0] prev_source;
	enc_byte_t expected_bytes[$];
	int mismatch_count = 0;
	int tx_idle_max = 4;
	int rx_idle_max = 4;
	int rx_hold_cycles = 0;

	position_delta_varint_encoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// zig-zag fold at 32 bits
	function automatic logic [31:0] zigzag32(input logic [31:0] v);
		return {v[30:0], 1'b0} ^ {32{v[31]}};
	endfunction

	// queue one varint, low payload first
	function automatic void queue_varint(input logic [31:0] code, input logic err);
		logic more;
		enc_byte_t b;
		do begin
			more = code > 32'h7f;
			b.code_byte = '0;
			b.code_byte[MORE_BIT] = more;
			b.code_byte[PAYLOAD_BITS-1:0] = code[PAYLOAD_BITS-1:0];
			b.last_of_entry = 1'b0;
			b.order_error = err;
			expected_bytes.insert(expected_bytes.size(), b);
			code = code >> PAYLOAD_BITS;
		end while (more);
	endfunction

	// expected bytes of one accepted entry; advances the previous entry
	function automatic void predict_entry(input logic [OFFSET_BITS-1:0] off,
		input logic [SOURCE_BITS-1:0] src, input logic stmt);
		logic [31:0] off_word;
		logic [31:0] d_off;
		logic [31:0] d_src;
		logic err;
		off_word = {1'b0, off};
		err = off_word < prev_offset;
		d_off = off_word - prev_offset;
		d_src = src - prev_source;
		if (!stmt)
			d_off = ~d_off;
		queue_varint(zigzag32(d_off), err);
		queue_varint(zigzag32(d_src), err);
		expected_bytes[expected_bytes.size()-1].last_of_entry = 1'b1;
		prev_offset = off_word;
		prev_source = src;
	endfunction

	// offer one entry, wait for it to be taken, then predict it
	task automatic send_entry(input logic [OFFSET_BITS-1:0] off,
		input logic [SOURCE_BITS-1:0] src, input logic stmt);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_BITS{1'b0}}, src, off};
		s_tuser <= stmt;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_entry(off, src, stmt);
	endtask

	// mostly growing offsets with nearby sources; some jumps and backward steps
	task automatic send_random_entry();
		int kind;
		logic [31:0] off;
		logic [31:0] src;
		kind = $urandom_range(0, 9);
		off = prev_offset + $urandom_range(0, 300);
		src = prev_source + ($urandom_range(0, 400) - 200);
		case (kind)
			6, 7: begin
				off = $urandom();
				src = $urandom();
			end
			8: begin
				off = prev_offset - $urandom_range(1, 1000);
			end
			9: begin
				off = prev_offset + ($urandom() >> $urandom_range(1, 31));
				src = $urandom();
			end
			default: ;
		endcase
		send_entry(off[OFFSET_BITS-1:0], src, 1'($urandom_range(0, 1)));
	endtask

	// hold the input idle until every expected byte has come out
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// output side: random stalls, one long hold-off on request, byte checks
	initial begin : byte_sink
		int stall;
		enc_byte_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles != 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = $urandom_range(0, rx_idle_max);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual byte %h last %b error %b",
					$time, m_tdata, m_tlast, m_tuser);
				mismatch_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.code_byte) begin
					$display("%0t: code_byte expected %h actual %h",
						$time, want.code_byte, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== want.last_of_entry) begin
					$display("%0t: last_of_entry expected %b actual %b",
						$time, want.last_of_entry, m_tlast);
					mismatch_count++;
				end
				if (m_tuser !== want.order_error) begin
					$display("%0t: order_error expected %b actual %b",
						$time, want.order_error, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// zero deltas, field extremes, varint length steps and backward offsets
	task automatic test_directed_extremes();
		send_entry(31'd0, 32'd0, 1'b1);
		send_entry(31'd0, 32'd0, 1'b0);
		send_entry(31'h7fffffff, 32'h7fffffff, 1'b1);
		send_entry(31'h7fffffff, 32'h80000000, 1'b0);
		send_entry(31'd0, 32'hffffffff, 1'b1);
		send_entry(31'd63, 32'd63, 1'b1);
		send_entry(31'd127, 32'd0, 1'b1);
		send_entry(31'd126, 32'hffffffc0, 1'b1);
		send_entry(31'd126, 32'hffffffc0, 1'b0);
		send_entry(31'd8318, 32'h00002000, 1'b1);
		send_entry(31'h40000000, 32'h80000000, 1'b1);
		send_entry(31'h3fffffff, 32'h7fffffff, 1'b0);
		send_entry(31'h7ffffffe, 32'h00000000, 1'b0);
		send_entry(31'h55555555, 32'haaaaaaaa, 1'b1);
		send_entry(31'h2aaaaaaa, 32'h55555555, 1'b0);
		send_entry(31'h2aaaaaaa, 32'h55555555, 1'b1);
	endtask

	task automatic test_random_positions(input int count);
		repeat (count) send_random_entry();
	endtask

	// back-to-back items on both sides
	task automatic test_unthrottled_stream(input int count);
		tx_idle_max = 0;
		rx_idle_max = 0;
		repeat (count) send_random_entry();
		tx_idle_max = 4;
		rx_idle_max = 4;
	endtask

	// receiver stops for a long stretch while entries keep coming
	task automatic test_receiver_holdoff(input int count);
		tx_idle_max = 0;
		rx_hold_cycles = HOLDOFF_CYCLES;
		repeat (count) send_random_entry();
		tx_idle_max = 4;
	endtask

	// sender stops until the output has run dry, then resumes
	task automatic test_drain_pause();
		repeat (5) send_random_entry();
		pause_until_drained();
		repeat (10) send_random_entry();
	endtask

	initial begin : stimulus
		prev_offset = '0;
		prev_source = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_random_positions(45);
		test_unthrottled_stream(25);
		test_receiver_holdoff(20);
		test_drain_pause();
		pause_until_drained();
		if (mismatch_count == 0) begin
			$display("position_delta_varint_encoder_unit verification clean");
		end else begin
			$display("position_delta_varint_encoder_unit verification failed");
		end
		$finish;
	end

	// watchdog well beyond the slowest correct run
	initial begin : watchdog
		#2000000;
		$display("position_delta_varint_encoder_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
